[rtl/core/ble_pkg.sv]
`default_nettype none

package ble_pkg;

    // Configuration port.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESTIMATE_MIN   = 1'b1;

    localparam logic [15:0] CACHE_INTERVAL_RST = 16'd2000;
    localparam logic [15:0] ESTIMATE_MIN_RST   = 16'd2500;

    localparam logic signed [7:0] PCT_UNKNOWN = -8'sd1;
    localparam logic [15:0]       PCT_MAX     = 16'd100;

    // Charge state codes in status bits 4:3.
    localparam logic [1:0] CHG_PRE  = 2'd1;
    localparam logic [1:0] CHG_FAST = 2'd2;

    // Resting LiPo discharge curve, highest voltage first.
    localparam int CURVE_POINTS = 9;
    localparam int SEG_W        = $clog2(CURVE_POINTS);
    localparam int SLOPE_W      = 15;

    localparam logic [15:0] CURVE_MV [CURVE_POINTS] = '{
        16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3800,
        16'd3700, 16'd3600, 16'd3500, 16'd3300
    };
    localparam logic [6:0] CURVE_PCT [CURVE_POINTS] = '{
        7'd100, 7'd90, 7'd78, 7'd60, 7'd42, 7'd22, 7'd8, 7'd3, 7'd0
    };

    // Segment i runs from point i up to point i-1. The slope is the rise of the
    // segment times 1311, and with the shift below it stands for rise / span:
    // 1311 / 2^17 is just above 1/100, and 2^18 serves the 200 mV segment.
    // The error stays below the smallest fractional step, so the floor holds.
    localparam logic [SLOPE_W-1:0] CURVE_SLOPE [CURVE_POINTS] = '{
        15'd0,     15'd13110, 15'd15732, 15'd23598, 15'd23598,
        15'd26220, 15'd18354, 15'd6555,  15'd3933
    };
    localparam logic CURVE_WIDE [CURVE_POINTS] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
    };
    localparam int SHIFT_NARROW = 17;
    localparam int SHIFT_WIDE   = 18;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        volt_ok;
        logic [15:0] volt_raw;
        logic        soc_ok;
        logic [15:0] soc_raw;
        logic        chg_ok;
        logic [7:0]  chg_status;
    } t_query;

    typedef struct packed {
        logic signed [7:0] percent;
        logic [15:0]       batt_mv;
        logic              charging;
        logic              refreshed;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/ble_stream_if.sv]
`default_nettype none

interface ble_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/ble_curve.sv]
`default_nettype none

module ble_curve (
    input  wire logic [15:0] i_mv,
    output logic [6:0]       o_pct
);
    localparam int PROD_W = ble_pkg::SLOPE_W + 8;

    logic                     hit;
    logic [ble_pkg::SEG_W-1:0] seg;
    logic [15:0]              delta;
    logic [PROD_W-1:0]        prod;
    logic [6:0]               frac_pct;

    // The curve falls, so the lowest index whose point lies at or below the
    // voltage names the segment; scanning downward lets that one win.
    always_comb begin
        hit = 1'b0;
        seg = ble_pkg::SEG_W'(1);
        for (int i = ble_pkg::CURVE_POINTS - 1; i >= 1; i--) begin
            if (i_mv >= ble_pkg::CURVE_MV[i]) begin
                hit = 1'b1;
                seg = ble_pkg::SEG_W'(i);
            end
        end
    end

    // Within a segment the offset stays below the span, at most 200 mV.
    assign delta = i_mv - ble_pkg::CURVE_MV[seg];
    assign prod  = ble_pkg::CURVE_SLOPE[seg] * delta[7:0];

    always_comb begin
        if (ble_pkg::CURVE_WIDE[seg]) begin
            frac_pct = 7'(prod >> ble_pkg::SHIFT_WIDE);
        end else begin
            frac_pct = 7'(prod >> ble_pkg::SHIFT_NARROW);
        end
    end

    always_comb begin
        if (i_mv >= ble_pkg::CURVE_MV[0]) begin
            o_pct = ble_pkg::CURVE_PCT[0];
        end else if (hit) begin
            o_pct = ble_pkg::CURVE_PCT[seg] + frac_pct;
        end else begin
            o_pct = ble_pkg::CURVE_PCT[ble_pkg::CURVE_POINTS-1];
        end
    end

endmodule

`default_nettype wire

[rtl/core/battery_level_estimator.sv]
`default_nettype none

// Channel   Dir  Payload                                        Transfer
// i_query   in   now_ms, volt/soc/chg readings with ok flags    valid & ready
// o_result  out  percent, batt_mv, charging, refreshed          valid & ready
// i_cfg_*   in   register index and 16-bit data                 i_cfg_we
//
// A query is captured in an input register and then resolved against the cache,
// and its result is loaded into the output register; one query per cycle is
// sustained while results are taken. The cache age compare and the curve
// multiply set the path between the two registers. Reset is synchronous and
// empties both registers and restores the cache and configuration. A stalled
// result holds both registers; i_query.ready then falls once the input register
// is full.

module battery_level_estimator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ble_stream_if.sink                           i_query,
    ble_stream_if.source                         o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [ble_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ble_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    logic [15:0] r_interval;
    logic [15:0] r_est_min;

    logic              r_in_valid;
    ble_pkg::t_query   r_in;
    logic              r_out_valid;
    ble_pkg::t_result  r_out;

    logic [31:0]       r_cache_time;
    logic signed [7:0] r_cache_pct;
    logic [15:0]       r_cache_volt;
    logic              r_cache_chg;

    logic [31:0]       n_cache_time;
    logic signed [7:0] n_cache_pct;
    logic [15:0]       n_cache_volt;
    logic              n_cache_chg;

    logic              advance;
    logic              refresh;
    logic [31:0]       age;
    logic [15:0]       volt;
    logic              soc_good;
    logic              use_est;
    logic [6:0]        est_pct;
    logic signed [7:0] pct;
    logic [1:0]        chg_state;
    logic              charging;

    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_query.ready  = !r_in_valid || advance;
    assign o_result.valid = r_out_valid;
    assign o_result.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= ble_pkg::CACHE_INTERVAL_RST;
            r_est_min  <= ble_pkg::ESTIMATE_MIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ble_pkg::CFG_CACHE_INTERVAL: r_interval <= i_cfg_data;
                ble_pkg::CFG_ESTIMATE_MIN:   r_est_min  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Refresh decision and the new cache contents.
    assign age     = r_in.now_ms - r_cache_time;
    assign refresh = (r_cache_time == '0) || (age >= {16'd0, r_interval});

    assign volt     = r_in.volt_ok ? r_in.volt_raw : 16'd0;
    assign soc_good = r_in.soc_ok && (r_in.soc_raw <= ble_pkg::PCT_MAX);
    assign use_est  = (!soc_good || (r_in.soc_raw == 16'd0)) && (volt > r_est_min);

    ble_curve u_curve (
        .i_mv  (volt),
        .o_pct (est_pct)
    );

    always_comb begin
        if (use_est) begin
            pct = $signed({1'b0, est_pct});
        end else if (soc_good) begin
            pct = $signed(r_in.soc_raw[7:0]);
        end else begin
            pct = ble_pkg::PCT_UNKNOWN;
        end
    end

    assign chg_state = r_in.chg_status[4:3];
    assign charging  = r_in.chg_ok && (chg_state inside {ble_pkg::CHG_PRE, ble_pkg::CHG_FAST});

    always_comb begin
        n_cache_time = r_cache_time;
        n_cache_pct  = r_cache_pct;
        n_cache_volt = r_cache_volt;
        n_cache_chg  = r_cache_chg;
        if (refresh) begin
            // Time zero would read as an empty cache, so it is stored as one.
            n_cache_time = (r_in.now_ms == '0) ? 32'd1 : r_in.now_ms;
            n_cache_pct  = pct;
            n_cache_volt = volt;
            n_cache_chg  = charging;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cache_time <= '0;
            r_cache_pct  <= ble_pkg::PCT_UNKNOWN;
            r_cache_volt <= '0;
            r_cache_chg  <= 1'b0;
        end else begin
            if (i_query.valid && i_query.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_cache_time <= n_cache_time;
                r_cache_pct  <= n_cache_pct;
                r_cache_volt <= n_cache_volt;
                r_cache_chg  <= n_cache_chg;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_query.valid && i_query.ready) begin
            r_in <= i_query.payload;
        end
        if (advance) begin
            r_out.percent   <= n_cache_pct;
            r_out.batt_mv   <= n_cache_volt;
            r_out.charging  <= n_cache_chg;
            r_out.refreshed <= refresh;
        end
    end

    // Once any query has been resolved the cache counts as filled.
    a_cache_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_cache_time != '0)
        else $error("cache time is zero after a resolved query");

    // The pending result always mirrors the cache it was taken from.
    a_out_matches_cache: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.batt_mv == r_cache_volt) &&
                        (r_out.percent == r_cache_pct) &&
                        (r_out.charging == r_cache_chg))
        else $error("result register differs from cache");

    // A full input register behind a stalled result must block new queries.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_result.ready) |-> !i_query.ready)
        else $error("query accepted while the pipeline is stalled");

    // A query that finds the cache fresh must leave it untouched.
    a_hold_when_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !refresh) |=> $stable(r_cache_time) && $stable(r_cache_volt))
        else $error("cache changed without a refresh");

    // The percent is either unknown or within 0 to 100.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.percent == ble_pkg::PCT_UNKNOWN) ||
                        (r_out.percent >= 8'sd0 && r_out.percent <= 8'sd100))
        else $error("percent out of range");

endmodule

`default_nettype wire
